[src/pcd_pkg.sv]
// Shared constants for the pair contact distance test pipeline.
// No dependencies; used by pcd_sqrt_step and pair_contact_distance_test_top.
`timescale 1ns / 1ps

package pcd_pkg;

   localparam int INDEX_BITS_DEF = 10;
   localparam int COORD_BITS_DEF = 24;

   localparam int RADIUS_BITS = 16;
   localparam int CUT_BITS    = RADIUS_BITS + 1;
   localparam int CUT_SQ_BITS = 2 * CUT_BITS;

   // Distance result and the radicand that the square root handles.
   localparam int DIST_BITS = 25;
   localparam int RAD_BITS  = 2 * DIST_BITS;
   localparam int REM_BITS  = DIST_BITS + 2;

endpackage

[src/pcd_sqrt_step.sv]
// One registered digit step of the restoring integer square root.
// Depends on pcd_pkg for the radicand, remainder and root widths.
`timescale 1ns / 1ps

module pcd_sqrt_step #(
   parameter int SIDE_BITS = 1
) (
   input  logic                               clock,
   input  logic                               load,
   input  logic [pcd_pkg::RAD_BITS-1:0]       rad_in,
   input  logic [pcd_pkg::REM_BITS-1:0]       rem_in,
   input  logic [pcd_pkg::DIST_BITS-1:0]      root_in,
   input  logic [SIDE_BITS-1:0]               side_in,
   output logic [pcd_pkg::RAD_BITS-1:0]       rad_ff,
   output logic [pcd_pkg::REM_BITS-1:0]       rem_ff,
   output logic [pcd_pkg::DIST_BITS-1:0]      root_ff,
   output logic [SIDE_BITS-1:0]               side_ff
);

   logic [pcd_pkg::REM_BITS-1:0]  rem_sh;
   logic [pcd_pkg::REM_BITS-1:0]  trial;
   logic                          fits;
   logic [pcd_pkg::RAD_BITS-1:0]  rad_step_in;
   logic [pcd_pkg::REM_BITS-1:0]  rem_step_in;
   logic [pcd_pkg::DIST_BITS-1:0] root_step_in;

   // Bring down the next two radicand bits and try root*4 + 1.
   always_comb begin
      rem_sh       = {rem_in[pcd_pkg::REM_BITS-3:0],
                      rad_in[pcd_pkg::RAD_BITS-1:pcd_pkg::RAD_BITS-2]};
      trial        = {root_in, 2'b01};
      fits         = (rem_sh >= trial);
      rem_step_in  = fits ? (rem_sh - trial) : rem_sh;
      root_step_in = {root_in[pcd_pkg::DIST_BITS-2:0], fits};
      rad_step_in  = {rad_in[pcd_pkg::RAD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rad_ff  <= rad_step_in;
         rem_ff  <= rem_step_in;
         root_ff <= root_step_in;
         side_ff <= side_in;
      end
   end

endmodule

[src/pair_contact_distance_test_top.sv]
// Pair contact distance test: top level with the arithmetic front end and the
// square root pipeline. Depends on pcd_pkg and pcd_sqrt_step.
// Throughput: one beat per cycle while rsp_ready is high; each of the 29 stages holds one item and
// advances when the stage after it is empty or moving, so bubbles close up.
// Reset: synchronous, active high; clears stage valid bits only.
`timescale 1ns / 1ps

module pair_contact_distance_test_top #(
   parameter int INDEX_BITS = pcd_pkg::INDEX_BITS_DEF,
   parameter int COORD_BITS = pcd_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [INDEX_BITS-1:0]               req_query_index,
   input  logic signed [COORD_BITS-1:0]        req_query_x,
   input  logic signed [COORD_BITS-1:0]        req_query_y,
   input  logic signed [COORD_BITS-1:0]        req_query_z,
   input  logic [pcd_pkg::RADIUS_BITS-1:0]     req_query_radius,
   input  logic [INDEX_BITS-1:0]               req_cand_index,
   input  logic signed [COORD_BITS-1:0]        req_cand_x,
   input  logic signed [COORD_BITS-1:0]        req_cand_y,
   input  logic signed [COORD_BITS-1:0]        req_cand_z,
   input  logic [pcd_pkg::RADIUS_BITS-1:0]     req_cand_radius,
   input  logic                                req_row_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_neighbor,
   output logic [INDEX_BITS-1:0]               rsp_neighbor_id,
   output logic [pcd_pkg::DIST_BITS-1:0]       rsp_distance,
   output logic                                rsp_row_last
);

   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_MIN  = SQ_BITS + 2;
   localparam int SUM_W    = (SUM_MIN > pcd_pkg::RAD_BITS + 1) ? SUM_MIN
                                                              : pcd_pkg::RAD_BITS + 1;
   localparam int FRONT    = 4;
   localparam int NST      = FRONT + pcd_pkg::DIST_BITS;
   // Sideband through the root stages: neighbor flag, id, row end, overflow.
   localparam int SIDE_BITS = INDEX_BITS + 3;

   // ---------------- stage control ----------------
   logic [NST-1:0] v_ff;
   logic [NST-1:0] adv;

   always_comb begin
      adv[NST-1] = !v_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 0: differences, cutoff, same node ----------------
   function automatic logic [COORD_BITS-1:0] abs_diff(
      input logic [COORD_BITS-1:0] a,
      input logic [COORD_BITS-1:0] b
   );
      logic [COORD_BITS:0] d_ab;
      logic [COORD_BITS:0] d_ba;
      d_ab = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      d_ba = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
      return d_ab[COORD_BITS] ? d_ba[COORD_BITS-1:0] : d_ab[COORD_BITS-1:0];
   endfunction

   logic [COORD_BITS-1:0]          dx_ff, dy_ff, dz_ff;
   logic [pcd_pkg::CUT_BITS-1:0]   cut_ff;
   logic                           same0_ff;
   logic [INDEX_BITS-1:0]          id0_ff;
   logic                           last0_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx_ff    <= abs_diff(req_cand_x, req_query_x);
         dy_ff    <= abs_diff(req_cand_y, req_query_y);
         dz_ff    <= abs_diff(req_cand_z, req_query_z);
         cut_ff   <= {1'b0, req_query_radius} + {1'b0, req_cand_radius};
         same0_ff <= (req_query_index == req_cand_index);
         id0_ff   <= req_cand_index;
         last0_ff <= req_row_end;
      end
   end

   // ---------------- stage 1: squares ----------------
   logic [SQ_BITS-1:0]              sqx_ff, sqy_ff, sqz_ff;
   logic [pcd_pkg::CUT_SQ_BITS-1:0] cut_sq1_ff;
   logic                            same1_ff;
   logic [INDEX_BITS-1:0]           id1_ff;
   logic                            last1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sqx_ff     <= dx_ff * dx_ff;
         sqy_ff     <= dy_ff * dy_ff;
         sqz_ff     <= dz_ff * dz_ff;
         cut_sq1_ff <= cut_ff * cut_ff;
         same1_ff   <= same0_ff;
         id1_ff     <= id0_ff;
         last1_ff   <= last0_ff;
      end
   end

   // ---------------- stage 2: sum of squares ----------------
   logic [SUM_W-1:0]                sum_ff;
   logic [pcd_pkg::CUT_SQ_BITS-1:0] cut_sq2_ff;
   logic                            same2_ff;
   logic [INDEX_BITS-1:0]           id2_ff;
   logic                            last2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sum_ff     <= {{(SUM_W-SQ_BITS){1'b0}}, sqx_ff}
                     + {{(SUM_W-SQ_BITS){1'b0}}, sqy_ff}
                     + {{(SUM_W-SQ_BITS){1'b0}}, sqz_ff};
         cut_sq2_ff <= cut_sq1_ff;
         same2_ff   <= same1_ff;
         id2_ff     <= id1_ff;
         last2_ff   <= last1_ff;
      end
   end

   // ---------------- stage 3: cutoff compare, range check ----------------
   logic [pcd_pkg::RAD_BITS-1:0] rad3_ff;
   logic [SIDE_BITS-1:0]         side3_ff;
   logic                         near3;
   logic                         over3;

   always_comb begin
      near3 = (sum_ff <= {{(SUM_W-pcd_pkg::CUT_SQ_BITS){1'b0}}, cut_sq2_ff});
      over3 = (sum_ff[SUM_W-1:pcd_pkg::RAD_BITS] != '0);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         rad3_ff  <= sum_ff[pcd_pkg::RAD_BITS-1:0];
         side3_ff <= {(!same2_ff && near3), id2_ff, last2_ff, over3};
      end
   end

   // ---------------- stages 4..: one root digit per stage ----------------
   logic [pcd_pkg::RAD_BITS-1:0]  rad_w  [0:pcd_pkg::DIST_BITS];
   logic [pcd_pkg::REM_BITS-1:0]  rem_w  [0:pcd_pkg::DIST_BITS];
   logic [pcd_pkg::DIST_BITS-1:0] root_w [0:pcd_pkg::DIST_BITS];
   logic [SIDE_BITS-1:0]          side_w [0:pcd_pkg::DIST_BITS];

   assign rad_w[0]  = rad3_ff;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign side_w[0] = side3_ff;

   for (genvar g = 0; g < pcd_pkg::DIST_BITS; g++) begin : g_root
      pcd_sqrt_step #(
         .SIDE_BITS (SIDE_BITS)
      ) u_step (
         .clock   (clock),
         .load    (adv[FRONT+g]),
         .rad_in  (rad_w[g]),
         .rem_in  (rem_w[g]),
         .root_in (root_w[g]),
         .side_in (side_w[g]),
         .rad_ff  (rad_w[g+1]),
         .rem_ff  (rem_w[g+1]),
         .root_ff (root_w[g+1]),
         .side_ff (side_w[g+1])
      );
   end

   // ---------------- result beat ----------------
   logic [SIDE_BITS-1:0] side_out;

   assign side_out        = side_w[pcd_pkg::DIST_BITS];
   assign rsp_valid       = v_ff[NST-1];
   assign rsp_is_neighbor = side_out[SIDE_BITS-1];
   assign rsp_neighbor_id = side_out[SIDE_BITS-2:2];
   assign rsp_row_last    = side_out[1];
   // Saturate when the squared distance is beyond the root's range.
   assign rsp_distance    = side_out[0] ? '1 : root_w[pcd_pkg::DIST_BITS];

endmodule
